// ----- design/rcs_pkg.sv -----
// Types and constants shared by the reversing contactor sequencer.
// Holds the step encoding, beat structs and register map; depends on nothing.
package rcs_pkg;

  typedef enum logic [3:0] {
    ST_STOP      = 4'd0,
    ST_ON_FWD    = 4'd1,
    ST_WAIT_FWD  = 4'd2,
    ST_FWD       = 4'd3,
    ST_ON_BWD    = 4'd4,
    ST_WAIT_BWD  = 4'd5,
    ST_BWD       = 4'd6,
    ST_OFF       = 4'd7,
    ST_WAIT_STOP = 4'd8,
    ST_EMERG     = 4'd9
  } step_t;

  typedef struct packed {
    logic       forward_switch;
    logic       backward_switch;
    logic       mains_present;
    logic       remote_valid;
    logic       remote_is_write;
    logic [1:0] remote_command;
  } in_item_t;

  typedef struct packed {
    logic       relay_forward;
    logic       relay_common;
    logic       power_switch;
    logic       led_forward;
    logic       led_backward;
    logic       led_emergency;
    logic [1:0] run_direction;
    logic [2:0] direction_status;
    logic       send_reply;
    logic [3:0] sequencer_state;
  } out_item_t;

  // Drive bit positions
  localparam int DB_RFWD = 0;
  localparam int DB_RCOM = 1;
  localparam int DB_PWR  = 2;
  localparam int DB_LFWD = 3;
  localparam int DB_LBWD = 4;
  localparam int DB_LEMG = 5;

  // Armed flag positions
  localparam int ARM_FWD  = 0;
  localparam int ARM_BWD  = 1;
  localparam int ARM_STOP = 2;

  // Remote commands
  localparam logic [1:0] CMD_FWD  = 2'd0;
  localparam logic [1:0] CMD_BWD  = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // Run direction codes
  localparam logic [1:0] RD_STOP = 2'd0;
  localparam logic [1:0] RD_FWD  = 2'd1;
  localparam logic [1:0] RD_BWD  = 2'd2;

  // Direction status codes
  localparam logic [2:0] DS_NONE     = 3'd0;
  localparam logic [2:0] DS_RUN_FWD  = 3'd1;
  localparam logic [2:0] DS_RUN_BWD  = 3'd2;
  localparam logic [2:0] DS_STOP_FWD = 3'd3;
  localparam logic [2:0] DS_STOP_BWD = 3'd4;

  // Register map, word index
  localparam logic [1:0] REG_PON   = 2'd0;
  localparam logic [1:0] REG_POFF  = 2'd1;
  localparam logic [1:0] REG_BLINK = 2'd2;

  localparam logic [15:0] PON_RESET   = 16'd1000;
  localparam logic [15:0] POFF_RESET  = 16'd1000;
  localparam logic [15:0] BLINK_RESET = 16'd500;

endpackage

// ----- design/reversing_contactor_sequencer.sv -----
// Reversing contactor sequencer top level: tick-driven motor relay sequencing.
// Uses rcs_pkg for the step encoding, beat structs and register map.
//
// Usage: every input beat on in_valid/in_stall is one tick carrying the local
// forward/backward switch levels, the mains sense and an optional remote command.
// Each accepted beat yields exactly one result beat on out_valid/out_stall with
// the relay, power and LED drives, direction codes and the sequencer step.
// A beat accepted at edge t is presented at out_data after edge t. Throughput is
// one beat per cycle while the receiver does not stall; the next-state logic is a
// single pass from the state registers to the result register.
// When the receiver stalls, the result register holds and in_stall rises as
// long as it is full and stalled; a beat is taken in the same cycle that the
// waiting result leaves.
// Delays (power_on_delay, power_off_delay, blink_period) are counted in ticks,
// not clocks, and are set through the APB port at byte addresses 0, 4 and 8.
// Write them only while the block is idle.
// Synchronous reset (rst_n low) puts the sequence in the stop step with all
// relays, power and LEDs off, timers idle and registers at their defaults.
module reversing_contactor_sequencer
  import rcs_pkg::*;
#(
  parameter int DELAY_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [32:0] DELAY_MAX = (33'd1 << DELAY_WIDTH) - 33'd1;

  // Configuration registers
  logic [15:0] pon_r, poff_r, blink_per_r;

  // Sequencer state
  step_t                  step_r, step_nxt;
  logic [1:0]             run_dir_r, run_dir_nxt;
  logic [2:0]             dir_st_r, dir_st_nxt;
  logic [2:0]             armed_r, armed_nxt;
  logic                   tp_on_r, tp_on_nxt;
  logic                   tp_off_r, tp_off_nxt;
  logic                   exp_mains_r, exp_mains_nxt;
  logic                   on_act_r, on_act_nxt;
  logic [DELAY_WIDTH-1:0] on_cnt_r, on_cnt_nxt;
  logic                   off_act_r, off_act_nxt;
  logic [DELAY_WIDTH-1:0] off_cnt_r, off_cnt_nxt;
  logic [15:0]            blink_r, blink_nxt;
  logic [5:0]             drive_r, drive_nxt;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic                   in_acc;
  logic                   cfg_wr;
  logic [DELAY_WIDTH-1:0] pon_clamp, poff_clamp;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if ({17'd0, pon_r} > DELAY_MAX) pon_clamp = DELAY_MAX[DELAY_WIDTH-1:0];
    else pon_clamp = DELAY_WIDTH'({17'd0, pon_r});
    if ({17'd0, poff_r} > DELAY_MAX) poff_clamp = DELAY_MAX[DELAY_WIDTH-1:0];
    else poff_clamp = DELAY_WIDTH'({17'd0, poff_r});
  end

  always_comb begin
    case (paddr[3:2])
      REG_PON:   prdata = {16'd0, pon_r};
      REG_POFF:  prdata = {16'd0, poff_r};
      REG_BLINK: prdata = {16'd0, blink_per_r};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pon_r       <= PON_RESET;
      poff_r      <= POFF_RESET;
      blink_per_r <= BLINK_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PON:   pon_r       <= pwdata[15:0];
        REG_POFF:  poff_r      <= pwdata[15:0];
        REG_BLINK: blink_per_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Next state for one tick
  always_comb begin
    step_nxt      = step_r;
    run_dir_nxt   = run_dir_r;
    dir_st_nxt    = dir_st_r;
    armed_nxt     = armed_r;
    tp_on_nxt     = tp_on_r;
    tp_off_nxt    = tp_off_r;
    exp_mains_nxt = exp_mains_r;
    on_act_nxt    = on_act_r;
    on_cnt_nxt    = on_cnt_r;
    off_act_nxt   = off_act_r;
    off_cnt_nxt   = off_cnt_r;
    blink_nxt     = blink_r;
    drive_nxt     = drive_r;

    // Advance countdowns before the step runs
    if (on_act_r) begin
      if (on_cnt_r <= DELAY_WIDTH'(1)) begin
        on_act_nxt = 1'b0;
        on_cnt_nxt = '0;
        tp_on_nxt  = 1'b1;
      end else begin
        on_cnt_nxt = on_cnt_r - DELAY_WIDTH'(1);
      end
    end
    if (off_act_r) begin
      if (off_cnt_r <= DELAY_WIDTH'(1)) begin
        off_act_nxt = 1'b0;
        off_cnt_nxt = '0;
        tp_off_nxt  = 1'b1;
        drive_nxt[DB_PWR] = 1'b0;
      end else begin
        off_cnt_nxt = off_cnt_r - DELAY_WIDTH'(1);
      end
    end

    // Local switches act once per press; both released re-arms
    if (in_data.forward_switch && !armed_nxt[ARM_FWD]) begin
      step_nxt = ST_ON_FWD;
      armed_nxt[ARM_FWD]  = 1'b1;
      armed_nxt[ARM_STOP] = 1'b0;
    end
    if (in_data.backward_switch && !armed_nxt[ARM_BWD]) begin
      step_nxt = ST_ON_BWD;
      armed_nxt[ARM_BWD]  = 1'b1;
      armed_nxt[ARM_STOP] = 1'b0;
    end
    if (!in_data.forward_switch && !in_data.backward_switch && !armed_nxt[ARM_STOP]) begin
      armed_nxt = 3'b000;
      armed_nxt[ARM_STOP] = 1'b1;
      step_nxt = ST_OFF;
    end

    if (in_data.remote_valid && in_data.remote_is_write) begin
      case (in_data.remote_command)
        CMD_FWD:  step_nxt = ST_ON_FWD;
        CMD_BWD:  step_nxt = ST_ON_BWD;
        CMD_STOP: step_nxt = ST_OFF;
        default: ;
      endcase
    end

    case (step_nxt)
      ST_ON_FWD, ST_ON_BWD: begin
        drive_nxt[DB_RCOM] = 1'b1;
        if (step_nxt == ST_ON_FWD) drive_nxt[DB_RFWD] = 1'b1;
        exp_mains_nxt = 1'b1;
        on_act_nxt    = 1'b1;
        on_cnt_nxt    = pon_clamp;
        step_nxt      = (step_nxt == ST_ON_FWD) ? ST_WAIT_FWD : ST_WAIT_BWD;
      end
      ST_WAIT_FWD, ST_WAIT_BWD: begin
        if (tp_on_nxt) begin
          tp_on_nxt = 1'b0;
          drive_nxt[DB_LFWD] = (step_nxt == ST_WAIT_FWD);
          drive_nxt[DB_LBWD] = (step_nxt == ST_WAIT_BWD);
          drive_nxt[DB_LEMG] = 1'b0;
          drive_nxt[DB_PWR]  = 1'b1;
          if (step_nxt == ST_WAIT_FWD) begin
            run_dir_nxt = RD_FWD;
            dir_st_nxt  = DS_RUN_FWD;
            step_nxt    = ST_FWD;
          end else begin
            run_dir_nxt = RD_BWD;
            dir_st_nxt  = DS_RUN_BWD;
            step_nxt    = ST_BWD;
          end
        end
      end
      ST_FWD, ST_BWD: begin
        if (!in_data.mains_present) step_nxt = ST_EMERG;
      end
      ST_OFF: begin
        drive_nxt[DB_RFWD] = 1'b0;
        drive_nxt[DB_RCOM] = 1'b0;
        exp_mains_nxt = 1'b0;
        off_act_nxt   = 1'b1;
        off_cnt_nxt   = poff_clamp;
        step_nxt      = ST_WAIT_STOP;
      end
      ST_WAIT_STOP: begin
        if (tp_off_nxt) begin
          tp_off_nxt = 1'b0;
          drive_nxt[DB_PWR]  = 1'b0;
          drive_nxt[DB_LFWD] = 1'b0;
          drive_nxt[DB_LBWD] = 1'b0;
          drive_nxt[DB_LEMG] = 1'b0;
          step_nxt    = ST_STOP;
          run_dir_nxt = RD_STOP;
          if (dir_st_nxt == DS_RUN_FWD) dir_st_nxt = DS_STOP_FWD;
          else if (dir_st_nxt == DS_RUN_BWD) dir_st_nxt = DS_STOP_BWD;
        end
      end
      ST_STOP: begin
        if (in_data.mains_present) step_nxt = ST_OFF;
      end
      ST_EMERG: begin
        if (blink_r >= blink_per_r) begin
          blink_nxt = 16'd0;
          drive_nxt[DB_LEMG] = !drive_nxt[DB_LEMG];
        end else begin
          blink_nxt = blink_r + 16'd1;
        end
        if (!exp_mains_nxt && !in_data.mains_present) step_nxt = ST_STOP;
      end
      default: step_nxt = ST_STOP;
    endcase

    out_data_nxt.relay_forward    = drive_nxt[DB_RFWD];
    out_data_nxt.relay_common     = drive_nxt[DB_RCOM];
    out_data_nxt.power_switch     = drive_nxt[DB_PWR];
    out_data_nxt.led_forward      = drive_nxt[DB_LFWD];
    out_data_nxt.led_backward     = drive_nxt[DB_LBWD];
    out_data_nxt.led_emergency    = drive_nxt[DB_LEMG];
    out_data_nxt.run_direction    = run_dir_nxt;
    out_data_nxt.direction_status = dir_st_nxt;
    out_data_nxt.send_reply       = in_data.remote_valid;
    out_data_nxt.sequencer_state  = step_nxt;

    out_valid_nxt = in_acc || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_STOP;
      run_dir_r   <= RD_STOP;
      dir_st_r    <= DS_NONE;
      armed_r     <= 3'b000;
      tp_on_r     <= 1'b0;
      tp_off_r    <= 1'b0;
      exp_mains_r <= 1'b0;
      on_act_r    <= 1'b0;
      on_cnt_r    <= '0;
      off_act_r   <= 1'b0;
      off_cnt_r   <= '0;
      blink_r     <= 16'd0;
      drive_r     <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        step_r      <= step_nxt;
        run_dir_r   <= run_dir_nxt;
        dir_st_r    <= dir_st_nxt;
        armed_r     <= armed_nxt;
        tp_on_r     <= tp_on_nxt;
        tp_off_r    <= tp_off_nxt;
        exp_mains_r <= exp_mains_nxt;
        on_act_r    <= on_act_nxt;
        on_cnt_r    <= on_cnt_nxt;
        off_act_r   <= off_act_nxt;
        off_cnt_r   <= off_cnt_nxt;
        blink_r     <= blink_nxt;
        drive_r     <= drive_nxt;
      end
    end
  end

  // Payload: load on accept only
  always_ff @(posedge clk) begin
    if (in_acc) out_data_r <= out_data_nxt;
  end

  a_fwd_dir: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == ST_FWD |-> run_dir_r == RD_FWD)
    else $error("forward step without forward run direction");

  a_bwd_dir: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == ST_BWD |-> run_dir_r == RD_BWD)
    else $error("backward step without backward run direction");

  a_led_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(drive_r[DB_LFWD] && drive_r[DB_LBWD]))
    else $error("forward and backward LEDs both lit");

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted beat produced no result");

endmodule

// ----- verif/tb_reversing_contactor_sequencer.sv -----
// Self-checking testbench for the reversing contactor sequencer top level.
// Drives tick beats with random gaps and stalls and predicts every result beat.
// Depends on rcs_pkg and reversing_contactor_sequencer.
`timescale 1ns / 1ps

module tb_reversing_contactor_sequencer
  import rcs_pkg::*;
;

  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int TMO_ON  = 0;
  localparam int TMO_OFF = 1;
  localparam int HOLD_AT    = 120;
  localparam int HOLD_LEN   = 60;
  localparam int CALM_FIRST = 250;
  localparam int CALM_LAST  = 350;
  localparam int IDLE_PCT   = 26;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  reversing_contactor_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow copy of the sequencer state and its delay registers
  logic [15:0] on_delay    = PON_RESET;
  logic [15:0] off_delay   = POFF_RESET;
  logic [15:0] blink_ticks = BLINK_RESET;
  step_t       seq_step    = ST_STOP;
  logic [1:0]  run_dir     = RD_STOP;
  logic [2:0]  dir_status  = DS_NONE;
  logic [2:0]  armed       = '0;
  logic [1:0]  tmo_pend    = '0;
  logic        want_mains  = 1'b0;
  logic        on_running  = 1'b0;
  logic [31:0] on_count    = '0;
  logic        off_running = 1'b0;
  logic [31:0] off_count   = '0;
  logic [15:0] blink_count = '0;
  logic [5:0]  drive       = '0;

  in_item_t  tick_queue[$];
  out_item_t expected_status[$];
  int        mismatches = 0;
  int        beats_in = 0;
  logic      in_taken = 1'b0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  // Level generator for well-formed switch and mains sequences
  bit lvl_fwd = 1'b0;
  bit lvl_bwd = 1'b0;
  bit lvl_mains = 1'b1;

  initial forever #2 clk = ~clk;

  initial begin
    #(400_000);
    $display("reversing_contactor_sequencer test failed");
    $finish;
  end

  function automatic out_item_t advance_sequencer(in_item_t t);
    out_item_t r;
    bit        fw;
    if (on_running) begin
      if (on_count <= 1) begin
        on_running = 1'b0;
        on_count = '0;
        tmo_pend[TMO_ON] = 1'b1;
      end else begin
        on_count = on_count - 1;
      end
    end
    if (off_running) begin
      if (off_count <= 1) begin
        off_running = 1'b0;
        off_count = '0;
        tmo_pend[TMO_OFF] = 1'b1;
        drive[DB_PWR] = 1'b0;
      end else begin
        off_count = off_count - 1;
      end
    end

    if (t.forward_switch && !armed[ARM_FWD]) begin
      seq_step = ST_ON_FWD;
      armed[ARM_FWD] = 1'b1;
      armed[ARM_STOP] = 1'b0;
    end
    if (t.backward_switch && !armed[ARM_BWD]) begin
      seq_step = ST_ON_BWD;
      armed[ARM_BWD] = 1'b1;
      armed[ARM_STOP] = 1'b0;
    end
    if (!t.forward_switch && !t.backward_switch && !armed[ARM_STOP]) begin
      armed = '0;
      armed[ARM_STOP] = 1'b1;
      seq_step = ST_OFF;
    end

    if (t.remote_valid && t.remote_is_write) begin
      case (t.remote_command)
        CMD_FWD:  seq_step = ST_ON_FWD;
        CMD_BWD:  seq_step = ST_ON_BWD;
        CMD_STOP: seq_step = ST_OFF;
        default: ;
      endcase
    end

    case (seq_step)
      ST_ON_FWD, ST_ON_BWD: begin
        drive[DB_RCOM] = 1'b1;
        if (seq_step == ST_ON_FWD) drive[DB_RFWD] = 1'b1;
        want_mains = 1'b1;
        on_running = 1'b1;
        on_count = 32'(on_delay);
        seq_step = (seq_step == ST_ON_FWD) ? ST_WAIT_FWD : ST_WAIT_BWD;
      end
      ST_WAIT_FWD, ST_WAIT_BWD: begin
        if (tmo_pend[TMO_ON]) begin
          fw = (seq_step == ST_WAIT_FWD);
          tmo_pend[TMO_ON] = 1'b0;
          drive[DB_LFWD] = fw;
          drive[DB_LBWD] = !fw;
          drive[DB_LEMG] = 1'b0;
          drive[DB_PWR] = 1'b1;
          seq_step = fw ? ST_FWD : ST_BWD;
          run_dir = fw ? RD_FWD : RD_BWD;
          dir_status = fw ? DS_RUN_FWD : DS_RUN_BWD;
        end
      end
      ST_FWD, ST_BWD: begin
        if (!t.mains_present) seq_step = ST_EMERG;
      end
      ST_OFF: begin
        drive[DB_RFWD] = 1'b0;
        drive[DB_RCOM] = 1'b0;
        want_mains = 1'b0;
        off_running = 1'b1;
        off_count = 32'(off_delay);
        seq_step = ST_WAIT_STOP;
      end
      ST_WAIT_STOP: begin
        if (tmo_pend[TMO_OFF]) begin
          tmo_pend[TMO_OFF] = 1'b0;
          drive[DB_PWR] = 1'b0;
          drive[DB_LFWD] = 1'b0;
          drive[DB_LBWD] = 1'b0;
          drive[DB_LEMG] = 1'b0;
          seq_step = ST_STOP;
          run_dir = RD_STOP;
          if (dir_status == DS_RUN_FWD) dir_status = DS_STOP_FWD;
          else if (dir_status == DS_RUN_BWD) dir_status = DS_STOP_BWD;
        end
      end
      ST_STOP: begin
        if (t.mains_present) seq_step = ST_OFF;
      end
      ST_EMERG: begin
        if (blink_count >= blink_ticks) begin
          blink_count = '0;
          drive[DB_LEMG] = !drive[DB_LEMG];
        end else begin
          blink_count = blink_count + 16'd1;
        end
        if (!want_mains && !t.mains_present) seq_step = ST_STOP;
      end
      default: seq_step = ST_STOP;
    endcase

    r.relay_forward    = drive[DB_RFWD];
    r.relay_common     = drive[DB_RCOM];
    r.power_switch     = drive[DB_PWR];
    r.led_forward      = drive[DB_LFWD];
    r.led_backward     = drive[DB_LBWD];
    r.led_emergency    = drive[DB_LEMG];
    r.run_direction    = run_dir;
    r.direction_status = dir_status;
    r.send_reply       = t.remote_valid;
    r.sequencer_state  = seq_step;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  function automatic bit calm_stretch();
    return beats_in >= CALM_FIRST && beats_in < CALM_LAST;
  endfunction

  // Sender: advance to the next beat only once the current one was taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (tick_queue.size() > 0 && (calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_data <= tick_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off that backs the block up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (calm_stretch()) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("relay_forward", want.relay_forward, out_data.relay_forward);
          check_field("relay_common", want.relay_common, out_data.relay_common);
          check_field("power_switch", want.power_switch, out_data.power_switch);
          check_field("led_forward", want.led_forward, out_data.led_forward);
          check_field("led_backward", want.led_backward, out_data.led_backward);
          check_field("led_emergency", want.led_emergency, out_data.led_emergency);
          check_field("run_direction", want.run_direction, out_data.run_direction);
          check_field("direction_status", want.direction_status, out_data.direction_status);
          check_field("send_reply", want.send_reply, out_data.send_reply);
          check_field("sequencer_state", want.sequencer_state, out_data.sequencer_state);
        end
      end
      if (in_valid && !in_stall) begin
        expected_status.push_back(advance_sequencer(in_data));
        beats_in++;
      end
      in_taken <= in_valid && !in_stall;
    end
  end

  task automatic push_tick(bit f, bit b, bit m, bit rv, bit rw, logic [1:0] cmd);
    in_item_t t;
    t.forward_switch  = f;
    t.backward_switch = b;
    t.mains_present   = m;
    t.remote_valid    = rv;
    t.remote_is_write = rw;
    t.remote_command  = cmd;
    tick_queue.push_back(t);
  endtask

  function automatic in_item_t make_tick();
    in_item_t   t;
    logic [6:0] raw;
    if ($urandom_range(0, 99) < 8) begin
      raw = 7'($urandom);
      t = in_item_t'(raw);
    end else begin
      if ($urandom_range(0, 9) == 0) lvl_fwd = !lvl_fwd;
      if ($urandom_range(0, 11) == 0) lvl_bwd = !lvl_bwd;
      if (lvl_mains) begin
        if ($urandom_range(0, 14) == 0) lvl_mains = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        lvl_mains = 1'b1;
      end
      t.forward_switch  = lvl_fwd;
      t.backward_switch = lvl_bwd;
      t.mains_present   = lvl_mains;
      t.remote_valid    = ($urandom_range(0, 5) == 0);
      t.remote_is_write = ($urandom_range(0, 2) != 0);
      t.remote_command  = 2'($urandom_range(0, 3));
    end
    return t;
  endfunction

  // Wait until every beat has gone through and the result register is empty
  task automatic wait_drained();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PON:   on_delay = value;
      REG_POFF:  off_delay = value;
      REG_BLINK: blink_ticks = value;
      default: ;
    endcase
  endtask

  task automatic run_random(logic [15:0] pon, logic [15:0] poff, logic [15:0] blink,
                            int count);
    write_reg(REG_PON, pon);
    write_reg(REG_POFF, poff);
    write_reg(REG_BLINK, blink);
    repeat (count) tick_queue.push_back(make_tick());
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset delays: a press starts the sequence but no timer expires
    push_tick(0, 0, 0, 0, 0, CMD_FWD);
    push_tick(1, 0, 1, 0, 0, CMD_FWD);
    push_tick(1, 0, 1, 1, 0, CMD_STOP);
    push_tick(0, 0, 1, 0, 0, CMD_FWD);
    wait_drained();

    write_reg(REG_PON, 16'd2);
    write_reg(REG_POFF, 16'd1);
    write_reg(REG_BLINK, 16'd1);
    // forward run, then mains loss into emergency with blinking
    repeat (4) push_tick(1, 0, 1, 0, 0, CMD_FWD);
    repeat (4) push_tick(1, 0, 0, 0, 0, CMD_FWD);
    // release re-arms and stops
    repeat (3) push_tick(0, 0, 0, 0, 0, CMD_FWD);
    // backward while forward is held keeps the forward relay
    repeat (3) push_tick(1, 0, 1, 0, 0, CMD_FWD);
    repeat (4) push_tick(1, 1, 1, 0, 0, CMD_FWD);
    // remote stop, forward, ignored command, read request, backward
    push_tick(1, 1, 1, 1, 1, CMD_STOP);
    push_tick(1, 1, 1, 1, 1, CMD_FWD);
    push_tick(1, 1, 1, 1, 1, CMD_IGNORED);
    push_tick(1, 1, 1, 1, 0, CMD_BWD);
    push_tick(1, 1, 1, 1, 1, CMD_BWD);
    wait_drained();

    run_random(16'd3, 16'd2, 16'd2, 300);
    run_random(16'd0, 16'd0, 16'd0, 150);
    run_random(16'hFFFF, 16'hFFFF, 16'hFFFF, 40);
    run_random(16'd7, 16'd5, 16'd1, 260);

    repeat (5) @(negedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_status.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("reversing_contactor_sequencer test passed");
    end else begin
      $display("reversing_contactor_sequencer test failed");
    end
    $finish;
  end

endmodule
